// ===== rtl/tnr_pkg.sv =====
// Package for the top-ten squared-L2 rerank block.
// Shared widths, the kept-list entry type and its cleared value.
// No dependencies.
package tnr_pkg;

    localparam int VAL_W          = 8;
    localparam int ID_W           = 20;
    localparam int DIST_W         = 23;
    localparam int RANK_W         = 4;
    localparam int KEEP_COUNT_DEF = 10;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    typedef struct packed {
        logic              valid;
        logic [DIST_W-1:0] distance;
        logic [ID_W-1:0]   id;
    } t_entry;

    // per-cycle command to every cell of the list
    typedef struct packed {
        logic ins;
        logic shl;
    } t_cell_ctl;

    function automatic t_entry clear_entry();
        t_entry e;
        e.valid    = 1'b0;
        e.distance = DIST_MAX;
        e.id       = '0;
        return e;
    endfunction

endpackage

// ===== rtl/tnr_if.sv =====
// Channel interfaces of the rerank block: input word and result word.
// Depends on tnr_pkg.
interface tnr_in_if import tnr_pkg::*;;
    logic               valid;
    logic               ready;
    logic [VAL_W-1:0]   query_value;
    logic [VAL_W-1:0]   base_value;
    logic [ID_W-1:0]    candidate_id;
    logic               last_component;
    logic               last_candidate;

    modport source (output valid, query_value, base_value, candidate_id,
                    last_component, last_candidate, input ready);
    modport sink   (input valid, query_value, base_value, candidate_id,
                    last_component, last_candidate, output ready);
endinterface

interface tnr_out_if import tnr_pkg::*;;
    logic               valid;
    logic               ready;
    logic [RANK_W-1:0]  rank;
    logic [ID_W-1:0]    neighbor_id;
    logic               neighbor_valid;
    logic [DIST_W-1:0]  neighbor_distance;
    logic               last_result;

    modport source (output valid, rank, neighbor_id, neighbor_valid,
                    neighbor_distance, last_result, input ready);
    modport sink   (input valid, rank, neighbor_id, neighbor_valid,
                    neighbor_distance, last_result, output ready);
endinterface

// ===== rtl/tnr_dist.sv =====
// Running squared-L2 accumulator, saturating at the distance width.
// Depends on tnr_pkg.
module tnr_dist import tnr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_last,
    input  logic [VAL_W-1:0]  i_query,
    input  logic [VAL_W-1:0]  i_base,
    output logic [DIST_W-1:0] o_dist
);

    logic [DIST_W-1:0]  r_sum;
    logic [VAL_W-1:0]   diff;
    logic [2*VAL_W-1:0] sq;
    logic [DIST_W:0]    sum_wide;

    always_comb begin
        diff     = (i_query > i_base) ? (i_query - i_base) : (i_base - i_query);
        sq       = diff * diff;
        sum_wide = {1'b0, r_sum} + (DIST_W+1)'(sq);
        // max sum stays below twice the cap, so the carry bit flags overflow
        o_dist   = sum_wide[DIST_W] ? DIST_MAX : sum_wide[DIST_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_accept) begin
            r_sum <= i_last ? '0 : o_dist;
        end
    end

endmodule

// ===== rtl/tnr_cell.sv =====
// One slot of the sorted kept list: compares, takes from the slot above on
// insert, from the slot below on drain. Depends on tnr_pkg.
module tnr_cell import tnr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_entry    i_new,
    input  t_entry    i_prev,
    input  logic      i_prev_beats,
    input  t_entry    i_next,
    output t_entry    o_entry,
    output logic      o_beats
);

    t_entry r_entry;
    t_entry n_entry;

    // empty slot loses to anything; ties keep the older entry
    assign o_beats = !r_entry.valid || (i_new.distance < r_entry.distance);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.shl) begin
            n_entry = i_next;
        end else if (i_ctl.ins && o_beats) begin
            n_entry = i_prev_beats ? i_prev : i_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= clear_entry();
        end else begin
            r_entry <= n_entry;
        end
    end

endmodule

// ===== rtl/top10_l2_nearest_rerank.sv =====
// Channel  Dir  Modport  Word
// i_in     in   sink     query_value, base_value, candidate_id, last_component,
//                        last_candidate
// o_out    out  source   rank, neighbor_id, neighbor_valid, neighbor_distance,
//                        last_result
//
// One input word per cycle while no drain runs; the insertion into the kept
// list happens in the cycle of the candidate's last component across the
// whole cell chain. After the query's last candidate, KEEP_COUNT result words
// drain from cell 0 at one per cycle, when the output is not stalled, while
// input is held off; the drain refills the list with empty slots.
// Synchronous active-low reset empties the list and the accumulator.
// A stalled output word holds and stretches the drain; input waits until it ends.
module top10_l2_nearest_rerank import tnr_pkg::*; #(
    parameter int KEEP_COUNT = KEEP_COUNT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tnr_in_if.sink    i_in,
    tnr_out_if.source o_out
);

    localparam int CNT_W = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;

    logic             r_emit;
    logic [CNT_W-1:0] r_rank;

    logic             in_acc;
    logic             out_acc;
    logic             rank_last;
    logic [DIST_W-1:0] cand_dist;
    t_entry           new_entry;
    t_cell_ctl        ctl;
    t_entry           w_entry [KEEP_COUNT];
    logic             w_beats [KEEP_COUNT];

    assign i_in.ready = !r_emit;
    assign in_acc     = i_in.valid && i_in.ready;
    assign out_acc    = o_out.valid && o_out.ready;
    assign rank_last  = (r_rank == CNT_W'(KEEP_COUNT - 1));

    tnr_dist u_dist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_acc),
        .i_last   (i_in.last_component),
        .i_query  (i_in.query_value),
        .i_base   (i_in.base_value),
        .o_dist   (cand_dist)
    );

    always_comb begin
        new_entry.valid    = 1'b1;
        new_entry.distance = cand_dist;
        new_entry.id       = i_in.candidate_id;
        ctl.ins            = in_acc && i_in.last_component;
        ctl.shl            = out_acc;
    end

    for (genvar g = 0; g < KEEP_COUNT; g++) begin : g_cell
        t_entry prev_e;
        t_entry next_e;
        logic   prev_b;

        if (g == 0) begin : g_head
            assign prev_e = clear_entry();
            assign prev_b = 1'b0;
        end else begin : g_body
            assign prev_e = w_entry[g-1];
            assign prev_b = w_beats[g-1];
        end

        if (g == KEEP_COUNT - 1) begin : g_tail
            assign next_e = clear_entry();
        end else begin : g_mid
            assign next_e = w_entry[g+1];
        end

        tnr_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (ctl),
            .i_new        (new_entry),
            .i_prev       (prev_e),
            .i_prev_beats (prev_b),
            .i_next       (next_e),
            .o_entry      (w_entry[g]),
            .o_beats      (w_beats[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit <= 1'b0;
            r_rank <= '0;
        end else if (r_emit) begin
            if (out_acc) begin
                r_rank <= rank_last ? '0 : r_rank + 1'b1;
                if (rank_last) begin
                    r_emit <= 1'b0;
                end
            end
        end else if (in_acc && i_in.last_component && i_in.last_candidate) begin
            r_emit <= 1'b1;
            r_rank <= '0;
        end
    end

    // result word comes straight from the head cell
    always_comb begin
        o_out.valid             = r_emit;
        o_out.rank              = RANK_W'(r_rank);
        o_out.neighbor_valid    = w_entry[0].valid;
        o_out.neighbor_id       = w_entry[0].valid ? w_entry[0].id : '0;
        o_out.neighbor_distance = w_entry[0].valid ? w_entry[0].distance : '0;
        o_out.last_result       = rank_last;
    end

endmodule
